FILE: rtl/fatrd_pkg.sv
// shared types and constants for the root directory name lookup
package fatrd_pkg;

	localparam int NAME_LEN     = 11;
	localparam int EXT_START    = 8;
	localparam int ROOT_ENTRIES = 224;

	localparam logic [7:0] SKIP_ATTR = 8'h18;
	localparam logic [7:0] SPACE     = 8'h20;
	localparam logic [7:0] DOT       = 8'h2E;
	localparam logic [7:0] NUL       = 8'h00;
	localparam logic [7:0] LOWER_A   = 8'h61;
	localparam logic [7:0] LOWER_Z   = 8'h7A;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	localparam logic REQ_CHAR  = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	typedef logic [NAME_LEN-1:0][7:0] name_t;
	typedef logic [3:0]               pos_t;
	typedef logic [7:0]               index_t;

	typedef struct packed {
		logic       char_go;
		logic       entry_go;
		logic       clear;
		logic [7:0] ch;
		logic       last;
	} pack_ctrl_t;

	typedef struct packed {
		logic        hit;
		logic        found;
		logic [31:0] size;
	} match_res_t;

endpackage

FILE: rtl/fatrd_name_pack.sv
// 8.3 name packing buffer and its position and end flags
module fatrd_name_pack import fatrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pack_ctrl_t ctrl,
	output name_t      name
);

	name_t name_q, name_d, eff_name;
	pos_t  pos_q, pos_d, eff_pos;
	logic  ended_q, ended_d, eff_ended;
	logic  complete_q, complete_d, eff_complete;
	logic [7:0] up_ch;

	always_comb begin
		eff_name     = ctrl.clear ? {NAME_LEN{SPACE}} : name_q;
		eff_pos      = ctrl.clear ? '0 : pos_q;
		eff_ended    = ctrl.clear ? 1'b0 : ended_q;
		eff_complete = ctrl.clear ? 1'b0 : complete_q;
		up_ch = ctrl.ch;
		if (ctrl.ch inside {[LOWER_A:LOWER_Z]}) begin
			up_ch = ctrl.ch - CASE_BIT;
		end
		name_d     = eff_name;
		pos_d      = eff_pos;
		ended_d    = eff_ended;
		complete_d = eff_complete;
		if (ctrl.char_go) begin
			if (!eff_ended && !eff_complete) begin
				if (ctrl.ch == NUL) begin
					ended_d = 1'b1;
				end else if (ctrl.ch == DOT && eff_pos <= pos_t'(EXT_START)) begin
					pos_d = pos_t'(EXT_START);
				end else if (eff_pos < pos_t'(NAME_LEN)) begin
					for (int k = 0; k < NAME_LEN; k++) begin
						if (eff_pos == pos_t'(k)) begin
							name_d[k] = up_ch;
						end
					end
					pos_d = eff_pos + pos_t'(1);
					if (eff_pos + pos_t'(1) >= pos_t'(NAME_LEN)) begin
						ended_d = 1'b1;
					end
				end
			end
			if (ctrl.last) begin
				complete_d = 1'b1;
			end
		end
		if (ctrl.entry_go) begin
			complete_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q     <= {NAME_LEN{SPACE}};
			pos_q      <= '0;
			ended_q    <= 1'b0;
			complete_q <= 1'b0;
		end else begin
			name_q     <= name_d;
			pos_q      <= pos_d;
			ended_q    <= ended_d;
			complete_q <= complete_d;
		end
	end

	assign name = name_q;

	// position never runs past the buffer
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= pos_t'(NAME_LEN))
		else $error("pack position beyond name length");

endmodule

FILE: rtl/fatrd_entry_match.sv
// directory entry compare, entry count and search end flag
module fatrd_entry_match import fatrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic        clear,
	input  name_t       name,
	input  logic [63:0] base_name,
	input  logic [23:0] extension,
	input  logic [7:0]  attr,
	input  logic [31:0] size,
	output logic        done,
	output match_res_t  res
);

	name_t  ent;
	index_t idx_q, idx_next;
	logic   done_q;
	logic   active, zero_first, name_eq;

	always_comb begin
		for (int k = 0; k < EXT_START; k++) begin
			ent[k] = base_name[63-8*k -: 8];
		end
		for (int k = EXT_START; k < NAME_LEN; k++) begin
			ent[k] = extension[23-8*(k-EXT_START) -: 8];
		end
	end

	assign active     = go && !done_q;
	assign zero_first = (ent[0] == NUL);
	assign name_eq    = ((attr & SKIP_ATTR) == 8'h00) && (ent == name);
	assign idx_next   = (idx_q == 8'hFF) ? idx_q : idx_q + index_t'(1);

	always_comb begin
		res = '0;
		if (active) begin
			if (zero_first) begin
				res.hit = 1'b1;
			end else if (name_eq) begin
				res.hit   = 1'b1;
				res.found = 1'b1;
				res.size  = size;
			end else if (idx_next >= index_t'(ROOT_ENTRIES)) begin
				res.hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			done_q <= 1'b0;
		end else if (clear) begin
			idx_q  <= '0;
			done_q <= 1'b0;
		end else if (active) begin
			if (!zero_first && !name_eq) begin
				idx_q <= idx_next;
			end
			if (res.hit) begin
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;

	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res.hit && !clear) |=> done_q)
		else $error("result without search end");

	a_clear_idx: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (idx_q == '0 && !done_q))
		else $error("new lookup did not reset the search");

endmodule

FILE: rtl/fat_root_dir_name_lookup.sv
// top level of the root directory 8.3 name lookup
// One transaction enters per cycle while in_ready is high: a file name character
// (req_type 0) or a root directory entry (req_type 1). Each goes through an input
// register, a single pass of packing or 11-byte compare logic, and a result register,
// so a result is offered from the result register once its transaction leaves the
// input register, and the block sustains one transaction per clock when the result
// side takes what it is offered. A lookup gives exactly one result: found with the
// file size on the first matching file entry, or not found on an entry with a zero
// first byte or at the 224th entry. A character after a result starts a new lookup.
module fat_root_dir_name_lookup import fatrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  name_char,
	input  logic        name_last,
	input  logic [63:0] entry_base_name,
	input  logic [23:0] entry_extension,
	input  logic [7:0]  entry_attr,
	input  logic [31:0] entry_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] file_size
);

	logic        valid_s1;
	logic        req_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic [63:0] base_s1;
	logic [23:0] ext_s1;
	logic [7:0]  attr_s1;
	logic [31:0] size_s1;

	logic        out_valid_q;
	logic        found_q;
	logic [31:0] size_q;

	logic        advance, done;
	pack_ctrl_t  pctrl;
	match_res_t  res;
	name_t       name;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_type;
			char_s1 <= name_char;
			last_s1 <= name_last;
			base_s1 <= entry_base_name;
			ext_s1  <= entry_extension;
			attr_s1 <= entry_attr;
			size_s1 <= entry_size;
		end
	end

	always_comb begin
		pctrl.char_go  = advance && (req_s1 == REQ_CHAR);
		pctrl.entry_go = advance && (req_s1 == REQ_ENTRY) && !done;
		pctrl.clear    = advance && (req_s1 == REQ_CHAR) && done;
		pctrl.ch       = char_s1;
		pctrl.last     = last_s1;
	end

	fatrd_name_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pctrl),
		.name   (name)
	);

	fatrd_entry_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance && (req_s1 == REQ_ENTRY)),
		.clear     (pctrl.clear),
		.name      (name),
		.base_name (base_s1),
		.extension (ext_s1),
		.attr      (attr_s1),
		.size      (size_s1),
		.done      (done),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			found_q <= res.found;
			size_q  <= res.size;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign file_size = size_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (size_q == 32'h0))
		else $error("not-found result with nonzero size");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q ##1 out_valid_q) |-> $past(valid_s1 && req_s1 == REQ_ENTRY))
		else $error("result without an entry transaction");

endmodule
